FILE: hw/rtl/gfba_pkg.sv
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared types and constants for the grouped free-block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 3;
    localparam int OFFSET_W = 6;

    // block held in stack entry 0 straight after reset
    localparam logic [WORD_W-1:0] FIRST_DATA_BLOCK = 16'd192;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REFILL = 2'd2;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_GRANTED        = 3'd0,
        KIND_EMPTY          = 3'd1,
        KIND_GRANTED_REFILL = 3'd2,
        KIND_SPILL          = 3'd3,
        KIND_FREED          = 3'd4,
        KIND_DONE           = 3'd5
    } kind_t;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REFILL = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   value;
        logic [OFFSET_W-1:0] word_offset;
        logic [WORD_W-1:0]   target_block;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gfba_if.sv
// ----------------------------------------------------------------------------
// gfba_in_if / gfba_out_if
// Valid/ready channels for requests and results of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] block_number;
    logic [15:0] refill_word;

    modport source (output valid, output func, output block_number,
                    output refill_word, input ready);
    modport sink (input valid, input func, input block_number,
                  input refill_word, output ready);
endinterface

interface gfba_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] value;
    logic [5:0]  word_offset;
    logic [15:0] target_block;
    logic        last;

    modport source (output valid, output kind, output value, output word_offset,
                    output target_block, output last, input ready);
    modport sink (input valid, input kind, input value, input word_offset,
                  input target_block, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/grouped_free_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Grouped-link free-block allocator with an on-chip stack of free blocks.
// ----------------------------------------------------------------------------
// The block keeps up to GROUP_SIZE free block numbers in a small stack RAM.
// An allocate pops the top entry; when that empties the stack the granted
// block is a group header and the host feeds its words back as refill
// requests, count first. A free pushes the block, or on a full stack spills
// the count and every entry as write words for the freed block and restarts
// the stack with it. Requests pass through a two-entry queue into the
// executing back end, so a request is taken while a result still waits.
// Push, refill word and rejected requests retire from the idle state; an
// allocate also passes through the pop state, as the stack RAM has a
// registered read port. A spilling free occupies the back end through the
// spill header and spill data states, one spill word per cycle through
// the single read port, when the result side takes a transfer every cycle.
// The stack needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_free_block_allocator
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gfba_in_if.sink    cmd,
    gfba_out_if.source result
);

    // queue towards the back end
    logic  q_valid;
    logic  q_ready;
    cmd_t  q_cmd;

    // result register contents
    logic  res_valid;
    rsp_t  res;

    gfba_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    gfba_back #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .res_valid (res_valid),
        .res_ready (result.ready),
        .res       (res)
    );

    // result transfer
    assign result.valid        = res_valid;
    assign result.kind         = res.kind;
    assign result.value        = res.value;
    assign result.word_offset  = res.word_offset;
    assign result.target_block = res.target_block;
    assign result.last         = res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/gfba_ram.sv
// ----------------------------------------------------------------------------
// gfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gfba_front.sv
// ----------------------------------------------------------------------------
// gfba_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_front
    import gfba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gfba_in_if.sink    cmd,
    output logic       q_valid,
    input  wire logic  q_ready,
    output cmd_t       q_cmd
);

    localparam int QUEUE_DEPTH = 2;

    cmd_t        entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        decoded;
    logic        push;
    logic        pop;

    // decode the function code
    always_comb
    begin
        decoded.op   = OP_NONE;
        decoded.data = cmd.block_number;
        case (cmd.func)
            FUNC_ALLOC:
            begin
                decoded.op = OP_ALLOC;
            end
            FUNC_FREE:
            begin
                decoded.op = OP_FREE;
            end
            FUNC_REFILL:
            begin
                decoded.op   = OP_REFILL;
                decoded.data = cmd.refill_word;
            end
            default:
            begin
                decoded.op = OP_NONE;
            end
        endcase
    end

    assign cmd.ready = (fill_reg != 2'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gfba_back.sv
// ----------------------------------------------------------------------------
// gfba_back
// Executes queued operations on the free-block stack and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_back
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_ready,
    input  wire cmd_t  q_cmd,
    output logic       res_valid,
    input  wire logic  res_ready,
    output rsp_t       res
);

    localparam int ADDR_W = $clog2(GROUP_SIZE);
    localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(GROUP_SIZE);
    localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(GROUP_SIZE - 1);
    localparam logic [WORD_W-1:0] WORD_FULL = WORD_W'(GROUP_SIZE);
    localparam logic [WORD_W-1:0] WORD_TERM = WORD_W'(GROUP_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE       = 4'b0001,
        S_POP        = 4'b0010,
        S_SPILL_HDR  = 4'b0100,
        S_SPILL_DATA = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                refilling_reg, refilling_next;
    logic [CNT_W-1:0]    remaining_reg, remaining_next;
    logic                have_count_reg, have_count_next;
    logic                skip_reg, skip_next;
    logic                pop_refill_reg, pop_refill_next;
    logic [WORD_W-1:0]   target_reg, target_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                init0_reg, init0_next;
    logic                rd_zero_reg;
    logic                res_valid_reg, res_valid_next;
    rsp_t                res_reg, res_next;

    logic                out_free;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [WORD_W-1:0]   wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   rd_data;
    logic [CNT_W-1:0]    clamped;
    logic [CNT_W-1:0]    rem_dec;

    function automatic rsp_t make_rsp(kind_t k, logic [WORD_W-1:0] v,
                                      logic [OFFSET_W-1:0] o,
                                      logic [WORD_W-1:0] t, logic l);
        rsp_t r;
        r.kind         = k;
        r.value        = v;
        r.word_offset  = o;
        r.target_block = t;
        r.last         = l;
        return r;
    endfunction

    gfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GROUP_SIZE)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // entry 0 reads as the first data block until it is written
    assign rd_data   = (rd_zero_reg && init0_reg) ? FIRST_DATA_BLOCK : ram_rdata;
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign clamped = (q_cmd.data > WORD_FULL) ? CNT_FULL : q_cmd.data[CNT_W-1:0];
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - CNT_W'(1) : '0;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        refilling_next  = refilling_reg;
        remaining_next  = remaining_reg;
        have_count_next = have_count_reg;
        skip_next       = skip_reg;
        pop_refill_next = pop_refill_reg;
        target_next     = target_reg;
        idx_next        = idx_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_next        = res_reg;
        q_ready         = 1'b0;
        we              = 1'b0;
        waddr           = count_reg[ADDR_W-1:0];
        wdata           = q_cmd.data;
        re              = 1'b0;
        raddr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    case (q_cmd.op)
                        OP_ALLOC:
                        begin
                            if (refilling_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                            end
                            else if (count_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(KIND_EMPTY, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                re              = 1'b1;
                                raddr           = ADDR_W'(count_reg - CNT_W'(1));
                                count_next      = count_reg - CNT_W'(1);
                                pop_refill_next = (count_reg == CNT_W'(1));
                                if (count_reg == CNT_W'(1))
                                begin
                                    refilling_next  = 1'b1;
                                    have_count_next = 1'b0;
                                    remaining_next  = '0;
                                    skip_next       = 1'b0;
                                end
                                state_next = S_POP;
                            end
                        end
                        OP_FREE:
                        begin
                            if (refilling_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                            end
                            else if (count_reg < CNT_FULL)
                            begin
                                we             = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                res_valid_next = 1'b1;
                                res_next = make_rsp(KIND_FREED, q_cmd.data, '0, '0, 1'b1);
                            end
                            else
                            begin
                                target_next = q_cmd.data;
                                state_next  = S_SPILL_HDR;
                            end
                        end
                        OP_REFILL:
                        begin
                            if (!refilling_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                            end
                            else if (!have_count_reg)
                            begin
                                count_next = '0;
                                if (clamped == '0)
                                begin
                                    refilling_next = 1'b0;
                                    remaining_next = '0;
                                    skip_next      = 1'b0;
                                    res_valid_next = 1'b1;
                                    res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                                end
                                else
                                begin
                                    skip_next       = (q_cmd.data == WORD_TERM);
                                    remaining_next  = clamped;
                                    have_count_next = 1'b1;
                                end
                            end
                            else if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else
                            begin
                                if (count_reg < CNT_FULL)
                                begin
                                    we         = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end
                                remaining_next = rem_dec;
                                if (rem_dec == '0)
                                begin
                                    refilling_next  = 1'b0;
                                    have_count_next = 1'b0;
                                    res_valid_next  = 1'b1;
                                    res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_next = make_rsp(KIND_DONE, '0, '0, '0, 1'b1);
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = make_rsp(pop_refill_reg ? KIND_GRANTED_REFILL : KIND_GRANTED,
                                        rd_data, '0, '0, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_SPILL_HDR:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next   = make_rsp(KIND_SPILL, WORD_FULL, '0, target_reg, 1'b0);
                    re         = 1'b1;
                    raddr      = '0;
                    idx_next   = '0;
                    state_next = S_SPILL_DATA;
                end
            end
            S_SPILL_DATA:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = make_rsp(KIND_SPILL, rd_data,
                                        OFFSET_W'(idx_reg) + OFFSET_W'(1),
                                        target_reg, idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST)
                    begin
                        // restart the stack with the freed block alone
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = target_reg;
                        count_next = CNT_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        init0_next = init0_reg && !(we && (waddr == '0));
    end

    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        target_reg     <= target_next;
        idx_reg        <= idx_next;
        pop_refill_reg <= pop_refill_next;
        if (re)
        begin
            rd_zero_reg <= (raddr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(1);
            refilling_reg  <= 1'b0;
            remaining_reg  <= '0;
            have_count_reg <= 1'b0;
            skip_reg       <= 1'b0;
            init0_reg      <= 1'b1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            refilling_reg  <= refilling_next;
            remaining_reg  <= remaining_next;
            have_count_reg <= have_count_next;
            skip_reg       <= skip_next;
            init0_reg      <= init0_next;
            res_valid_reg  <= res_valid_next;
        end
    end

endmodule

`default_nettype wire
